// ===== src/otwo_pkg.sv =====
package otwo_pkg;

    localparam int TRIG_BITS_DEF = 12;
    localparam logic [31:0] GAIN_LAT_RST  = 32'd370060;
    localparam logic [31:0] GAIN_FWD_RST  = 32'd213650;
    localparam logic [31:0] GAIN_TURN_RST = 32'd349824;
    localparam logic [9:0]  TPS_RST       = 10'd10;
    localparam logic [31:0] CORDIC_K      = 32'd652032874;

    localparam logic [1:0] REG_GAIN_LAT  = 2'd0;
    localparam logic [1:0] REG_GAIN_FWD  = 2'd1;
    localparam logic [1:0] REG_GAIN_TURN = 2'd2;
    localparam logic [1:0] REG_TPS       = 2'd3;

    typedef struct packed {
        logic signed [31:0] count0;
        logic signed [31:0] count1;
        logic signed [31:0] count2;
    } t_in;

    typedef struct packed {
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic        [31:0] heading;
        logic signed [31:0] speed_lateral;
        logic signed [31:0] speed_forward;
        logic signed [31:0] turn_rate;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_out;

    // datapath operation issued by the controller
    typedef enum logic [3:0] {
        OP_NONE, OP_DELTA, OP_SUMS, OP_LAT, OP_FWD, OP_TURN,
        OP_CINIT, OP_CITER, OP_CDONE, OP_ROTA, OP_ROTB, OP_POSE, OP_VEL
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       second;   // second trig pass: half heading
        logic [3:0] iter;
    } t_cmd;

    function automatic logic [31:0] atan_turn(input logic [3:0] i);
        logic [31:0] r;
        begin
            case (i)
                4'd0:  r = 32'h20000000;
                4'd1:  r = 32'h12E4051E;
                4'd2:  r = 32'h09FB385B;
                4'd3:  r = 32'h051111D4;
                4'd4:  r = 32'h028B0D43;
                4'd5:  r = 32'h0145D7E1;
                4'd6:  r = 32'h00A2F61E;
                4'd7:  r = 32'h00517C55;
                4'd8:  r = 32'h0028BE53;
                4'd9:  r = 32'h00145F2F;
                4'd10: r = 32'h000A2F98;
                4'd11: r = 32'h000517CC;
                4'd12: r = 32'h00028BE6;
                4'd13: r = 32'h000145F3;
                4'd14: r = 32'h0000A2FA;
                default: r = 32'h0000517D;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== src/otwo_ctrl.sv =====
module otwo_ctrl
    import otwo_pkg::*;
#(
    parameter int TRIG_BITS = TRIG_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_stall,
    output logic o_in_stall,
    output logic o_out_valid,
    output logic o_load,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_KIN   = 7'b0000010,
        S_TRIG  = 7'b0000100,
        S_ROT   = 7'b0001000,
        S_TRIG2 = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_step, n_step;
    logic       accept;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_load      = accept;

    always_comb begin
        n_state = r_state;
        n_step  = r_step + 5'd1;
        o_cmd   = '{op: OP_NONE, second: 1'b0, iter: 4'd0};
        unique case (r_state)
            S_IDLE: begin
                n_step = 5'd0;
                if (accept) begin
                    n_state = S_KIN;
                end
            end
            S_KIN: begin
                case (r_step)
                    5'd0: o_cmd.op = OP_DELTA;
                    5'd1: o_cmd.op = OP_SUMS;
                    5'd2: o_cmd.op = OP_LAT;
                    5'd3: o_cmd.op = OP_FWD;
                    default: o_cmd.op = OP_TURN;
                endcase
                if (r_step == 5'd4) begin
                    n_state = S_TRIG;
                    n_step  = 5'd0;
                end
            end
            S_TRIG, S_TRIG2: begin
                o_cmd.second = (r_state == S_TRIG2);
                o_cmd.iter   = 4'(r_step - 5'd1);
                if (r_step == 5'd0) begin
                    o_cmd.op = OP_CINIT;
                end else if (r_step <= 5'(TRIG_BITS)) begin
                    o_cmd.op = OP_CITER;
                end else begin
                    o_cmd.op = OP_CDONE;
                    n_state  = (r_state == S_TRIG) ? S_ROT : S_FIN;
                    n_step   = 5'd0;
                end
            end
            S_ROT: begin
                case (r_step)
                    5'd0: o_cmd.op = OP_ROTA;
                    5'd1: o_cmd.op = OP_ROTB;
                    default: o_cmd.op = OP_POSE;
                endcase
                if (r_step == 5'd2) begin
                    n_state = S_TRIG2;
                    n_step  = 5'd0;
                end
            end
            S_FIN: begin
                o_cmd.op = OP_VEL;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 5'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// ===== src/otwo_dp.sv =====
module otwo_dp
    import otwo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_in         i_in,
    input  t_cmd        i_cmd,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output t_out        o_out
);

    logic [31:0] r_gl, r_gf, r_gt;
    logic [9:0]  r_tps;
    logic [31:0] r_last [3];
    logic signed [31:0] r_px, r_py;
    logic [31:0] r_hd;
    logic [31:0] r_c0, r_c1, r_c2;
    logic signed [31:0] r_d0, r_d1, r_d2;
    logic signed [34:0] r_slat, r_sfwd, r_stsum;
    logic signed [31:0] r_lat, r_fwd;
    logic signed [49:0] r_trq;   // floor(tsum*gt/2^16), fits 50 bits; clipped later
    logic [31:0] r_dhead;
    logic signed [33:0] r_cx, r_cy;
    logic signed [33:0] r_cz;
    logic       r_flip;
    logic signed [15:0] r_sn, r_cs;
    logic signed [48:0] r_pa, r_pb;
    t_out       r_out;

    // 35x33 signed product split in two 16-bit gain halves
    function automatic logic signed [63:0] mulq16(input logic signed [34:0] s,
                                                  input logic [31:0] g);
        logic signed [63:0] hi, lo;
        begin
            hi = 64'(s) * $signed({1'b0, g[31:16]});
            lo = 64'(s) * $signed({1'b0, g[15:0]});
            return hi + (lo >>> 16);
        end
    endfunction

    function automatic logic signed [31:0] clamp(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] toq15(input logic signed [33:0] v);
        logic signed [34:0] q;
        begin
            q = (35'(v) + 35'sd16384) >>> 15;
            if (q > 35'sd32767) return 16'sh7FFF;
            if (q < -35'sd32768) return 16'sh8000;
            return q[15:0];
        end
    endfunction

    logic [31:0] ang, angf;
    logic        big;
    logic signed [33:0] shx, shy;
    logic signed [33:0] az;
    logic signed [63:0] m0, m1;
    logic signed [42:0] tpsx;

    assign ang  = i_cmd.second ? {1'b0, r_hd[31:1]} : r_hd;
    assign big  = ($signed(ang) > 32'sh40000000) || ($signed(ang) < -32'sh40000000);
    assign angf = ang + 32'h80000000;
    assign shx  = r_cx >>> i_cmd.iter;
    assign shy  = r_cy >>> i_cmd.iter;
    assign az   = $signed({2'b00, atan_turn(i_cmd.iter)});
    assign tpsx = $signed({33'd0, r_tps});

    always_comb begin
        m0 = '0;
        m1 = '0;
        case (i_cmd.op)
            OP_LAT:  m0 = mulq16(r_slat, r_gl);
            OP_FWD:  m0 = mulq16(r_sfwd, r_gf);
            OP_TURN: begin
                m0 = mulq16(r_stsum, r_gt);
                m1 = 64'(r_stsum) * $signed({1'b0, r_gt});
            end
            OP_ROTA: begin
                m0 = 64'(r_lat) * 64'(r_cs);
                m1 = 64'(r_lat) * 64'(r_sn);
            end
            OP_ROTB: begin
                m0 = 64'(r_fwd) * 64'(r_sn);
                m1 = 64'(r_fwd) * 64'(r_cs);
            end
            OP_VEL: begin
                m0 = 64'(r_lat) * 64'(tpsx);
                m1 = 64'(r_fwd) * 64'(tpsx);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gl    <= GAIN_LAT_RST;
            r_gf    <= GAIN_FWD_RST;
            r_gt    <= GAIN_TURN_RST;
            r_tps   <= TPS_RST;
            r_last[0] <= '0;
            r_last[1] <= '0;
            r_last[2] <= '0;
            r_px    <= '0;
            r_py    <= '0;
            r_hd    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_GAIN_LAT:  r_gl  <= i_cfg_data;
                    REG_GAIN_FWD:  r_gf  <= i_cfg_data;
                    REG_GAIN_TURN: r_gt  <= i_cfg_data;
                    REG_TPS:       r_tps <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            case (i_cmd.op)
                OP_DELTA: begin
                    r_last[0] <= r_c0;
                    r_last[1] <= r_c1;
                    r_last[2] <= r_c2;
                end
                OP_POSE: begin
                    r_px <= clamp(64'(r_px) + 64'(r_pa >>> 15));
                    r_py <= clamp(64'(r_py) + 64'(r_pb >>> 15));
                    r_hd <= r_hd + r_dhead;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_c0 <= i_in.count0;
            r_c1 <= i_in.count1;
            r_c2 <= i_in.count2;
        end
        case (i_cmd.op)
            OP_DELTA: begin
                r_d0 <= $signed(r_c0 - r_last[0]);
                r_d1 <= $signed(r_c1 - r_last[1]);
                r_d2 <= $signed(r_c2 - r_last[2]);
            end
            OP_SUMS: begin
                r_slat  <= 35'(r_d0) - 35'(r_d2);
                r_sfwd  <= -35'(r_d0) + (35'(r_d1) <<< 1) - 35'(r_d2);
                r_stsum <= -(35'(r_d0) + 35'(r_d1) + 35'(r_d2));
            end
            OP_LAT: r_lat <= clamp(m0);
            OP_FWD: r_fwd <= clamp(m0);
            OP_TURN: begin
                r_trq   <= m0[49:0];
                r_dhead <= m1[31:0];
            end
            OP_CINIT: begin
                r_cx   <= 34'(CORDIC_K);
                r_cy   <= '0;
                r_flip <= big;
                r_cz   <= big ? 34'($signed(angf)) : 34'($signed(ang));
            end
            OP_CITER: begin
                if (!r_cz[33]) begin
                    r_cx <= r_cx - shy;
                    r_cy <= r_cy + shx;
                    r_cz <= r_cz - az;
                end else begin
                    r_cx <= r_cx + shy;
                    r_cy <= r_cy - shx;
                    r_cz <= r_cz + az;
                end
            end
            OP_CDONE: begin
                r_sn <= toq15(r_flip ? -r_cy : r_cy);
                r_cs <= toq15(r_flip ? -r_cx : r_cx);
            end
            OP_ROTA: begin
                r_pa <= m0[48:0];
                r_pb <= m1[48:0];
            end
            OP_ROTB: begin
                r_pa <= r_pa - m0[48:0];
                r_pb <= r_pb + m1[48:0];
            end
            OP_VEL: begin
                r_out.position_x    <= r_px;
                r_out.position_y    <= r_py;
                r_out.heading       <= r_hd;
                r_out.speed_lateral <= clamp(m0);
                r_out.speed_forward <= clamp(m1);
                r_out.quat_z        <= r_sn;
                r_out.quat_w        <= r_cs;
            end
            default: ;
        endcase
        // turn rate: clip the quotient first; |clip*tps| matches clamp of full product
        if (i_cmd.op == OP_CINIT && !i_cmd.second) begin
            r_out.turn_rate <= clamp(64'(clamp(64'(r_trq) >>> 0)) * 64'(tpsx)) ;
        end
    end

    assign o_out = r_out;

endmodule

// ===== src/omni_three_wheel_odometry_core.sv =====
// One item at a time: o_in_stall stays high from input transfer until the result is taken,
// so output stall time delays the next item; the shared
// CORDIC unit runs twice per item, one iteration a cycle.
// Reset (synchronous, active low) loads the register defaults and clears counts and pose.
module omni_three_wheel_odometry_core
    import otwo_pkg::*;
#(
    parameter int TRIG_BITS = TRIG_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic load;
    t_cmd cmd;

    otwo_ctrl #(.TRIG_BITS(TRIG_BITS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_load      (load),
        .o_cmd       (cmd)
    );

    otwo_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_in       (i_in_data),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out      (o_out_data)
    );

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("input taken while result pending");
    a_out_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> !o_out_valid) else $error("result too early");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import otwo_pkg::*;

    localparam int  N_RANDOM   = 1240;
    localparam int  DRAIN_WAIT = TRIG_BITS_DEF * 2 + 30;
    localparam longint CORDIC_GAIN = 64'sd652032874;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    omni_three_wheel_odometry_core dut (.*);

    // odometry predictor state and registers
    bit [31:0] gain_lat, gain_fwd, gain_turn;
    bit [9:0]  tick_rate;
    bit [31:0] last_cnt [3];
    int        pose_x, pose_y;
    bit [31:0] pose_head;

    t_out pose_queue [$];
    int   err_count;
    int   hold_left;
    bit   out_quiet;
    bit   in_quiet;

    localparam bit [31:0] ATAN_STEP [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint scale_q16(input longint s, input bit [31:0] g);
        longint g_hi, g_lo;
        g_hi = g >> 16;
        g_lo = g & 32'h0000FFFF;
        return s * g_hi + ((s * g_lo) >>> 16);
    endfunction

    function automatic longint round_q15(input longint v);
        longint q;
        q = (v + 64'sd16384) >>> 15;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q;
    endfunction

    task automatic cordic_sincos(input bit [31:0] ang, output longint sn, output longint cs);
        longint z, x, y, dx, dy;
        bit     flip;
        z = longint'(signed'(ang));
        x = CORDIC_GAIN;
        y = 0;
        flip = 1'b0;
        // fold into the right half plane
        if (z > 64'sh40000000 || z < -64'sh40000000) begin
            z = longint'(signed'(ang + 32'h80000000));
            flip = 1'b1;
        end
        for (int i = 0; i < TRIG_BITS_DEF && i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= longint'(ATAN_STEP[i]);
            end else begin
                x += dx;
                y -= dy;
                z += longint'(ATAN_STEP[i]);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        sn = round_q15(y);
        cs = round_q15(x);
    endtask

    task automatic predict_pose(input t_in v);
        longint    d [3];
        bit [31:0] cnt [3];
        longint    lat, fwd, tsum, trate, tps, gt, sn, cs, qs, qc, dxp, dyp;
        bit [31:0] dhead;
        t_out      r;
        cnt[0] = v.count0;
        cnt[1] = v.count1;
        cnt[2] = v.count2;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'(signed'(cnt[i] - last_cnt[i]));
            last_cnt[i] = cnt[i];
        end
        tps = tick_rate;
        gt = gain_turn;
        lat = sat32(scale_q16(d[0] - d[2], gain_lat));
        fwd = sat32(scale_q16(-d[0] + 2 * d[1] - d[2], gain_fwd));
        tsum = -(d[0] + d[1] + d[2]);
        dhead = 32'(tsum * gt);
        trate = sat32(scale_q16(tsum, gain_turn) * tps);
        cordic_sincos(pose_head, sn, cs);
        dxp = (lat * cs - fwd * sn) >>> 15;
        dyp = (lat * sn + fwd * cs) >>> 15;
        pose_x = int'(sat32(longint'(pose_x) + dxp));
        pose_y = int'(sat32(longint'(pose_y) + dyp));
        pose_head = pose_head + dhead;
        cordic_sincos(pose_head >> 1, qs, qc);
        r.position_x    = pose_x;
        r.position_y    = pose_y;
        r.heading       = pose_head;
        r.speed_lateral = 32'(sat32(lat * tps));
        r.speed_forward = 32'(sat32(fwd * tps));
        r.turn_rate     = 32'(trate);
        r.quat_z        = 16'(qs);
        r.quat_w        = 16'(qc);
        pose_queue.push_back(r);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_counts(input t_in v);
        int gap;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = v;
        do @(posedge i_clk); while (o_in_stall);
        predict_pose(v);
        gap = in_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            i_in_data  = {$urandom, $urandom, $urandom};
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drain();
        // drop a valid left over from a back-to-back send
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pose_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input bit [31:0] val);
        wait_drain();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_GAIN_LAT:  gain_lat = val;
            REG_GAIN_FWD:  gain_fwd = val;
            REG_GAIN_TURN: gain_turn = val;
            default:       tick_rate = val[9:0];
        endcase
    endtask

    task automatic set_gains(input bit [31:0] gl, gf, gt, input bit [9:0] tps);
        write_reg(REG_GAIN_LAT, gl);
        write_reg(REG_GAIN_FWD, gf);
        write_reg(REG_GAIN_TURN, gt);
        write_reg(REG_TPS, {22'($urandom_range(0, 4194303)), tps});
    endtask

    // mostly small moves from the current counts, sometimes a wild jump
    function automatic t_in next_counts();
        t_in v;
        int  r;
        r = $urandom_range(0, 99);
        if (r < 10) return {$urandom, $urandom, $urandom};
        v.count0 = last_cnt[0] + 32'($signed($urandom_range(0, 4000)) - 2000);
        v.count1 = last_cnt[1] + 32'($signed($urandom_range(0, 4000)) - 2000);
        v.count2 = last_cnt[2] + 32'($signed($urandom_range(0, 4000)) - 2000);
        if (r < 20) v.count1 = last_cnt[1] + $urandom;
        return v;
    endfunction

    task automatic test_directed();
        send_counts('{0, 0, 0});
        send_counts('{100, 200, 300});
        send_counts('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
        // encoder wrap through the signed limit
        send_counts('{32'h80000000, 32'h80000000, 32'h80000000});
        send_counts('{32'h80000000, 32'h7FFFFFFF, 32'h00000000});
        send_counts('{32'hFFFFFFFF, 32'h00000001, 32'h80000001});
        send_counts('{-1000, 5000, -1000});
        send_counts('{0, 0, 0});
        // heading wraps with a large turn gain
        set_gains(32'h12345678, 32'h87654321, 32'h40000000, 10'd1);
        for (int i = 1; i <= 6; i++) send_counts('{i, -2 * i, i});
        for (int i = 1; i <= 4; i++) send_counts('{-3 * i, i, 7 * i});
        // zero tick rate, saturating positions
        set_gains(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 10'd0);
        send_counts('{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF});
        send_counts('{32'h80000000, 32'h7FFFFFFF, 32'h00000000});
        send_counts('{0, 0, 0});
    endtask

    task automatic test_config_sweep();
        bit [9:0] rates [4] = '{10'd1, 10'd1000, 10'd1023, 10'd0};
        set_gains(0, 0, 0, 10'd1000);
        for (int i = 0; i < 15; i++) send_counts(next_counts());
        for (int k = 0; k < 4; k++) begin
            set_gains($urandom, $urandom_range(0, 2000000), $urandom, rates[k]);
            for (int i = 0; i < 15; i++) send_counts(next_counts());
        end
        set_gains(GAIN_LAT_RST, GAIN_FWD_RST, GAIN_TURN_RST, TPS_RST);
    endtask

    task automatic test_pressure();
        @(posedge i_clk);
        hold_left = 700;
        in_quiet = 1'b1;
        for (int i = 0; i < 12; i++) send_counts(next_counts());
        in_quiet = 1'b0;
    endtask

    task automatic test_random();
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 100 == 0) begin
                in_quiet  = ($urandom_range(0, 3) == 0);
                out_quiet = ($urandom_range(0, 3) == 0);
            end
            if (i % 300 == 299)
                set_gains($urandom_range(0, 1000000), $urandom_range(0, 1000000),
                          $urandom, 10'($urandom_range(1, 1000)));
            send_counts(next_counts());
        end
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
    endtask

    // output stall: short random bursts, rare long ones, and forced hold-offs
    int stall_burst;
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_burst > 0) begin
            stall_burst <= stall_burst - 1;
            i_out_stall <= 1'b1;
        end else if (!out_quiet && $urandom_range(0, 99) < 25) begin
            stall_burst <= ($urandom_range(0, 49) == 0) ? $urandom_range(20, 80)
                                                        : $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [31:0] got, exp_val);
        if (got !== exp_val) begin
            err_count++;
            if (err_count <= 10)
                $display("mismatch %s: expected %h got %h at %0t", name, exp_val, got, $time);
        end
    endtask

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pose_queue.size() == 0) begin
                err_count++;
                if (err_count <= 10) $display("unexpected result at %0t", $time);
            end else begin
                e = pose_queue.pop_front();
                check_field("position_x", o_out_data.position_x, e.position_x);
                check_field("position_y", o_out_data.position_y, e.position_y);
                check_field("heading", o_out_data.heading, e.heading);
                check_field("speed_lateral", o_out_data.speed_lateral, e.speed_lateral);
                check_field("speed_forward", o_out_data.speed_forward, e.speed_forward);
                check_field("turn_rate", o_out_data.turn_rate, e.turn_rate);
                check_field("quat_z", {16'd0, o_out_data.quat_z}, {16'd0, e.quat_z});
                check_field("quat_w", {16'd0, o_out_data.quat_w}, {16'd0, e.quat_w});
            end
        end
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_GAIN_LAT;
        i_cfg_data = '0;
        err_count = 0;
        hold_left = 0;
        stall_burst = 0;
        out_quiet = 1'b0;
        in_quiet = 1'b0;
        gain_lat = GAIN_LAT_RST;
        gain_fwd = GAIN_FWD_RST;
        gain_turn = GAIN_TURN_RST;
        tick_rate = TPS_RST;
        last_cnt = '{0, 0, 0};
        pose_x = 0;
        pose_y = 0;
        pose_head = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_config_sweep();
        test_pressure();
        test_random();

        wait_drain();
        if (err_count == 0 && pose_queue.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
